FILE: rtl/core/rsi_pkg.sv
// Types and fixed widths shared by the ray-sphere intersection pipeline.
`default_nettype none

package rsi_pkg;

  localparam int CoordW = 32;
  localparam int RadW   = 31;
  localparam int DistW  = 32;
  localparam int LW     = 33;
  localparam int AW     = 64;
  localparam int HW     = 67;
  localparam int CW     = 68;
  localparam int HMW    = 66;
  localparam int CMW    = 67;
  localparam int DiscW  = 132;
  localparam int RootW  = 66;
  localparam int NumW   = 67;
  localparam int QW     = 32;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [RadW-1:0]          radius;
  } rsi_in_t;

  typedef struct packed {
    logic             hit;
    logic             far_root;
    logic [DistW-1:0] distance;
  } rsi_out_t;

  typedef struct packed {
    logic [AW-1:0]        a;
    logic signed [HW-1:0] h;
    logic signed [CW-1:0] c;
  } rsi_quad_t;

  typedef struct packed {
    logic [AW-1:0]  a;
    logic [HMW-1:0] hm;
    logic           hneg;
    logic           near;
    logic           miss;
  } rsi_side_t;

endpackage

`default_nettype wire

FILE: rtl/core/rsi_dot.sv
// Difference vector, component products and the quadratic coefficients a, h and c.
`default_nettype none

module rsi_dot
  import rsi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  rsi_in_t   data_i,
  output logic      valid_o,
  output rsi_quad_t quad_o
);

  logic signed [LW-1:0]       org_e [3];
  logic signed [LW-1:0]       ctr_e [3];
  logic signed [CoordW-1:0]   dir_e [3];
  logic signed [LW-1:0]       l_d [3];
  logic signed [LW-1:0]       l_q [3];
  logic signed [CoordW-1:0]   d_q [3];
  logic [RadW-1:0]            r_q;

  logic signed [2*CoordW-1:0] dd_d [3];
  logic signed [LW+CoordW-1:0] ld_d [3];
  logic signed [2*LW-1:0]     ll_d [3];
  logic [2*CoordW-2:0]        dd_q [3];
  logic signed [LW+CoordW-1:0] ld_q [3];
  logic [2*LW-2:0]            ll_q [3];
  logic [2*RadW-1:0]          rr_d;
  logic [2*RadW-1:0]          rr_q;

  logic [CMW-1:0]             llsum;
  rsi_quad_t                  quad_d;
  rsi_quad_t                  quad_q;
  logic                       v1_q, v2_q, v3_q;

  assign org_e[0] = {data_i.origin_x[CoordW-1], data_i.origin_x};
  assign org_e[1] = {data_i.origin_y[CoordW-1], data_i.origin_y};
  assign org_e[2] = {data_i.origin_z[CoordW-1], data_i.origin_z};
  assign ctr_e[0] = {data_i.center_x[CoordW-1], data_i.center_x};
  assign ctr_e[1] = {data_i.center_y[CoordW-1], data_i.center_y};
  assign ctr_e[2] = {data_i.center_z[CoordW-1], data_i.center_z};
  assign dir_e[0] = data_i.dir_x;
  assign dir_e[1] = data_i.dir_y;
  assign dir_e[2] = data_i.dir_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l_d[i]  = org_e[i] - ctr_e[i];
      dd_d[i] = d_q[i] * d_q[i];
      ld_d[i] = l_q[i] * d_q[i];
      ll_d[i] = l_q[i] * l_q[i];
    end
    rr_d = r_q * r_q;
  end

  always_comb begin
    llsum    = CMW'(ll_q[0]) + CMW'(ll_q[1]) + CMW'(ll_q[2]);
    quad_d.a = AW'(dd_q[0]) + AW'(dd_q[1]) + AW'(dd_q[2]);
    quad_d.h = HW'(ld_q[0]) + HW'(ld_q[1]) + HW'(ld_q[2]);
    quad_d.c = $signed({1'b0, llsum}) - $signed(CW'(rr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q    <= l_d;
      d_q    <= dir_e;
      r_q    <= data_i.radius;
      for (int i = 0; i < 3; i++) begin
        dd_q[i] <= dd_d[i][2*CoordW-2:0];
        ll_q[i] <= ll_d[i][2*LW-2:0];
      end
      ld_q   <= ld_d;
      rr_q   <= rr_d;
      quad_q <= quad_d;
    end
  end

  assign valid_o = v3_q;
  assign quad_o  = quad_q;

endmodule

`default_nettype wire

FILE: rtl/core/rsi_disc.sv
// Magnitudes, split wide products and the discriminant with root selection.
`default_nettype none

module rsi_disc
  import rsi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  rsi_quad_t        quad_i,
  output logic             valid_o,
  output logic [DiscW-1:0] disc_o,
  output rsi_side_t        side_o
);

  localparam int HLoW = 33;
  localparam int HHiW = HMW - HLoW;
  localparam int ALoW = 32;
  localparam int AHiW = AW - ALoW;
  localparam int CLoW = 34;
  localparam int CHiW = CMW - CLoW;

  logic [AW-1:0]  a4_q;
  logic [HMW-1:0] hm4_q;
  logic [CMW-1:0] cm4_q;
  logic           hneg4_q, cneg4_q, czero4_q, azero4_q;

  logic [2*HLoW-1:0]      phll_d, phll_q;
  logic [HLoW+HHiW-1:0]   phlh_d, phlh_q;
  logic [2*HHiW-1:0]      phhh_d, phhh_q;
  logic [ALoW+CLoW-1:0]   palcl_d, palcl_q;
  logic [ALoW+CHiW-1:0]   palch_d, palch_q;
  logic [AHiW+CLoW-1:0]   pahcl_d, pahcl_q;
  logic [AHiW+CHiW-1:0]   pahch_d, pahch_q;
  logic [AW-1:0]  a5_q;
  logic [HMW-1:0] hm5_q;
  logic           hneg5_q, cneg5_q, czero5_q, azero5_q;

  logic [DiscW-1:0] h2_d, h2_q, ac_d, ac_q;
  logic [AW-1:0]  a6_q;
  logic [HMW-1:0] hm6_q;
  logic           hneg6_q, cneg6_q, czero6_q, azero6_q;

  logic             ge;
  logic [DiscW-1:0] disc_d, disc_q;
  rsi_side_t        side_d, side_q;
  logic             v4_q, v5_q, v6_q, v7_q;

  assign phll_d  = hm4_q[HLoW-1:0] * hm4_q[HLoW-1:0];
  assign phlh_d  = hm4_q[HLoW-1:0] * hm4_q[HMW-1:HLoW];
  assign phhh_d  = hm4_q[HMW-1:HLoW] * hm4_q[HMW-1:HLoW];
  assign palcl_d = a4_q[ALoW-1:0] * cm4_q[CLoW-1:0];
  assign palch_d = a4_q[ALoW-1:0] * cm4_q[CMW-1:CLoW];
  assign pahcl_d = a4_q[AW-1:ALoW] * cm4_q[CLoW-1:0];
  assign pahch_d = a4_q[AW-1:ALoW] * cm4_q[CMW-1:CLoW];

  assign h2_d = (DiscW'(phhh_q) << (2*HLoW)) + (DiscW'(phlh_q) << (HLoW+1))
              + DiscW'(phll_q);
  assign ac_d = (DiscW'(pahch_q) << (ALoW+CLoW)) + (DiscW'(palch_q) << CLoW)
              + (DiscW'(pahcl_q) << ALoW) + DiscW'(palcl_q);

  always_comb begin
    ge          = h2_q >= ac_q;
    disc_d      = cneg6_q ? h2_q + ac_q : h2_q - ac_q;
    side_d.a    = a6_q;
    side_d.hm   = hm6_q;
    side_d.hneg = hneg6_q;
    side_d.near = hneg6_q && !cneg6_q && !czero6_q;
    side_d.miss = azero6_q || (!cneg6_q && !ge) || (!hneg6_q && !cneg6_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a4_q     <= quad_i.a;
      hm4_q    <= quad_i.h[HW-1] ? HMW'(-quad_i.h) : HMW'(quad_i.h);
      cm4_q    <= quad_i.c[CW-1] ? CMW'(-quad_i.c) : CMW'(quad_i.c);
      hneg4_q  <= quad_i.h[HW-1];
      cneg4_q  <= quad_i.c[CW-1];
      czero4_q <= quad_i.c == '0;
      azero4_q <= quad_i.a == '0;

      phll_q   <= phll_d;
      phlh_q   <= phlh_d;
      phhh_q   <= phhh_d;
      palcl_q  <= palcl_d;
      palch_q  <= palch_d;
      pahcl_q  <= pahcl_d;
      pahch_q  <= pahch_d;
      a5_q     <= a4_q;
      hm5_q    <= hm4_q;
      hneg5_q  <= hneg4_q;
      cneg5_q  <= cneg4_q;
      czero5_q <= czero4_q;
      azero5_q <= azero4_q;

      h2_q     <= h2_d;
      ac_q     <= ac_d;
      a6_q     <= a5_q;
      hm6_q    <= hm5_q;
      hneg6_q  <= hneg5_q;
      cneg6_q  <= cneg5_q;
      czero6_q <= czero5_q;
      azero6_q <= azero5_q;

      disc_q   <= disc_d;
      side_q   <= side_d;
    end
  end

  assign valid_o = v7_q;
  assign disc_o  = disc_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

FILE: rtl/core/rsi_sqrt.sv
// Pipelined integer square root of the discriminant, one root bit per stage.
`default_nettype none

module rsi_sqrt
  import rsi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DiscW-1:0] disc_i,
  input  rsi_side_t        side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output rsi_side_t        side_o
);

  logic [DiscW-1:0] rem_in [RootW];
  logic [DiscW-1:0] trial  [RootW];
  logic [DiscW-1:0] rem_d  [RootW];
  logic [DiscW-1:0] rem_q  [RootW];
  logic [RootW-1:0] root_in [RootW];
  logic [RootW-1:0] root_d  [RootW];
  logic [RootW-1:0] root_q  [RootW];
  rsi_side_t        side_q  [RootW];
  logic [RootW-1:0] v_q;

  always_comb begin
    rem_in[0]  = disc_i;
    root_in[0] = '0;
    for (int j = 1; j < RootW; j++) begin
      rem_in[j]  = rem_q[j-1];
      root_in[j] = root_q[j-1];
    end
    for (int j = 0; j < RootW; j++) begin
      trial[j] = (DiscW'(root_in[j]) << (RootW-j)) | (DiscW'(1) << (2*(RootW-1-j)));
      if (rem_in[j] >= trial[j]) begin
        rem_d[j]  = rem_in[j] - trial[j];
        root_d[j] = root_in[j] | (RootW'(1) << (RootW-1-j));
      end else begin
        rem_d[j]  = rem_in[j];
        root_d[j] = root_in[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RootW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q     <= rem_d;
      root_q    <= root_d;
      side_q[0] <= side_i;
      for (int j = 1; j < RootW; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign valid_o = v_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

`default_nettype wire

FILE: rtl/core/rsi_div.sv
// Root numerator, saturation check and pipelined restoring division by a.
`default_nettype none

module rsi_div
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RootW-1:0] root_i,
  input  rsi_side_t        side_i,
  output logic             valid_o,
  output rsi_out_t         data_o
);

  localparam int NumSW = NumW + FRAC_BITS;
  localparam int RemW  = (NumSW > AW + QW) ? NumSW : AW + QW;

  logic [NumW-1:0] num_d, num_q;
  logic [AW-1:0]   aa_q;
  logic            missa_q, neara_q, va_q;

  logic [RemW-1:0] nums, bound;
  logic [RemW-1:0] remb_q;
  logic [AW-1:0]   ab_q;
  logic            satb_q, missb_q, nearb_q, vb_q;

  logic [RemW-1:0] rem_in [QW];
  logic [RemW-1:0] sub    [QW];
  logic [RemW-1:0] rem_d  [QW];
  logic [RemW-1:0] rem_q  [QW];
  logic [QW-1:0]   q_in   [QW];
  logic [QW-1:0]   q_d    [QW];
  logic [QW-1:0]   q_q    [QW];
  logic [AW-1:0]   a_in   [QW];
  logic [AW-1:0]   a_q    [QW];
  logic [QW-1:0]   sat_q, miss_q, near_q, v_q;

  rsi_out_t out_d, out_q;
  logic     vo_q;

  always_comb begin
    if (side_i.near) begin
      num_d = NumW'(side_i.hm) - NumW'(root_i);
    end else if (side_i.hneg) begin
      num_d = NumW'(side_i.hm) + NumW'(root_i);
    end else if (root_i >= side_i.hm) begin
      num_d = NumW'(root_i) - NumW'(side_i.hm);
    end else begin
      num_d = '0;
    end
  end

  assign nums  = RemW'(num_q) << FRAC_BITS;
  assign bound = RemW'(aa_q) << QW;

  always_comb begin
    rem_in[0] = remb_q;
    q_in[0]   = '0;
    a_in[0]   = ab_q;
    for (int j = 1; j < QW; j++) begin
      rem_in[j] = rem_q[j-1];
      q_in[j]   = q_q[j-1];
      a_in[j]   = a_q[j-1];
    end
    for (int j = 0; j < QW; j++) begin
      sub[j] = RemW'(a_in[j]) << (QW-1-j);
      if (rem_in[j] >= sub[j]) begin
        rem_d[j] = rem_in[j] - sub[j];
        q_d[j]   = q_in[j] | (QW'(1) << (QW-1-j));
      end else begin
        rem_d[j] = rem_in[j];
        q_d[j]   = q_in[j];
      end
    end
  end

  always_comb begin
    out_d.hit      = !miss_q[QW-1];
    out_d.far_root = !miss_q[QW-1] && !near_q[QW-1];
    if (miss_q[QW-1]) begin
      out_d.distance = '0;
    end else if (sat_q[QW-1]) begin
      out_d.distance = '1;
    end else begin
      out_d.distance = q_q[QW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      v_q  <= '0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      v_q  <= {v_q[QW-2:0], vb_q};
      vo_q <= v_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= num_d;
      aa_q    <= side_i.a;
      missa_q <= side_i.miss;
      neara_q <= side_i.near;

      remb_q  <= nums;
      ab_q    <= aa_q;
      satb_q  <= nums >= bound;
      missb_q <= missa_q;
      nearb_q <= neara_q;

      rem_q   <= rem_d;
      q_q     <= q_d;
      a_q     <= a_in;
      sat_q   <= {sat_q[QW-2:0], satb_q};
      miss_q  <= {miss_q[QW-2:0], missb_q};
      near_q  <= {near_q[QW-2:0], nearb_q};

      out_q   <= out_d;
    end
  end

  assign valid_o = vo_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/ray_sphere_intersection.sv
// Throughput: one beat per cycle while the output beat is not held.
// The 66-stage square root and the 32-stage divider set the depth.
// A held output beat stalls every stage at once; in_ready_o is out_ready_i || !out_valid_o.
// Reset clears all valid bits asynchronously; the data registers are not reset.
// Top level of the fixed-point ray-sphere intersection pipeline.
`default_nettype none

module ray_sphere_intersection
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rsi_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rsi_out_t out_data_o
);

  logic             en;
  logic             dot_valid, disc_valid, sqrt_valid;
  rsi_quad_t        quad;
  logic [DiscW-1:0] disc;
  rsi_side_t        disc_side, sqrt_side;
  logic [RootW-1:0] root;

  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  rsi_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (dot_valid),
    .quad_o  (quad)
  );

  rsi_disc u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dot_valid),
    .quad_i  (quad),
    .valid_o (disc_valid),
    .disc_o  (disc),
    .side_o  (disc_side)
  );

  rsi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (disc_valid),
    .disc_i  (disc),
    .side_i  (disc_side),
    .valid_o (sqrt_valid),
    .root_o  (root),
    .side_o  (sqrt_side)
  );

  rsi_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .root_i  (root),
    .side_i  (sqrt_side),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rsi_checker.sv
// Port-level checks on the ray-sphere intersection pipeline, bound to the top level.
`default_nettype none

module rsi_checker
  import rsi_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input rsi_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused while the output register is empty");

  a_ready_when_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input refused while the output beat is being taken");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |->
      !out_data_o.far_root && out_data_o.distance == '0)
    else $error("miss beat carries a root flag or distance");

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: test/ray_sphere_intersection_tb.sv
// Self-checking testbench for the fixed-point ray-sphere intersection pipeline.
`default_nettype none

module ray_sphere_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;

  localparam int FracBits = 16;
  localparam int TailCycles = 150;

  typedef logic signed [139:0] wide_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  rsi_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  rsi_out_t out_data_o;

  rsi_out_t expected_q[$];
  int       mismatches = 0;
  int       unexpected = 0;
  int       n_hits = 0;
  int       n_far = 0;
  int       n_misses = 0;
  int       n_saturated = 0;
  bit       sender_idle = 1'b0;
  bit       receiver_idle = 1'b0;
  int       stall_left = 0;

  ray_sphere_intersection #(
    .FRAC_BITS(FracBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic rsi_out_t predict_intersection(rsi_in_t b);
    wide_t lx, ly, lz, dx, dy, dz, r, a, h, c, disc, root, cand, num;
    rsi_out_t res;
    logic near;
    res = '0;
    lx = wide_t'($signed(b.origin_x)) - wide_t'($signed(b.center_x));
    ly = wide_t'($signed(b.origin_y)) - wide_t'($signed(b.center_y));
    lz = wide_t'($signed(b.origin_z)) - wide_t'($signed(b.center_z));
    dx = wide_t'($signed(b.dir_x));
    dy = wide_t'($signed(b.dir_y));
    dz = wide_t'($signed(b.dir_z));
    r  = wide_t'({1'b0, b.radius});
    a = dx * dx + dy * dy + dz * dz;
    h = lx * dx + ly * dy + lz * dz;
    c = lx * lx + ly * ly + lz * lz - r * r;
    if (a == 0) return res;
    disc = h * h - a * c;
    if (disc < 0) return res;
    if (h < 0 && c > 0) begin
      near = 1'b1;
    end else if (h < 0 || c < 0) begin
      near = 1'b0;
    end else begin
      return res;
    end
    root = 0;
    for (int k = 67; k >= 0; k--) begin
      cand = root | (wide_t'(1) << k);
      if (cand * cand <= disc) root = cand;
    end
    num = near ? -h - root : -h + root;
    if (num < 0) num = 0;
    num = num <<< FracBits;
    if (num >= (a <<< 32)) begin
      res.distance = '1;
    end else begin
      num = num / a;
      res.distance = num[31:0];
    end
    res.hit = 1'b1;
    res.far_root = !near;
    return res;
  endfunction

  // Input beats are predicted as they are accepted; output beats are checked in order.
  always @(posedge clk_i) begin
    rsi_out_t exp_beat;
    if (in_valid_i && in_ready_o) expected_q = {expected_q, predict_intersection(in_data_i)};
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with nothing expected: %p", out_data_o);
      end else begin
        exp_beat = expected_q.pop_front();
        if (out_data_o !== exp_beat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: hit %0b/%0b far_root %0b/%0b distance %08h/%08h (exp/act)",
                     exp_beat.hit, out_data_o.hit, exp_beat.far_root, out_data_o.far_root,
                     exp_beat.distance, out_data_o.distance);
        end
        if (!exp_beat.hit) n_misses++;
        else n_hits++;
        if (exp_beat.far_root) n_far++;
        if (exp_beat.hit && exp_beat.distance == '1) n_saturated++;
      end
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      out_ready_i = 1'b1;
      if (receiver_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic send_beat(rsi_in_t beat);
    int gap;
    gap = (sender_idle && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i = beat;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic rsi_in_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                       int cx, int cy, int cz, int rad);
    rsi_in_t b;
    b.origin_x = ox; b.origin_y = oy; b.origin_z = oz;
    b.dir_x = dx; b.dir_y = dy; b.dir_z = dz;
    b.center_x = cx; b.center_y = cy; b.center_z = cz;
    b.radius = rad[30:0];
    return b;
  endfunction

  function automatic rsi_in_t random_noise();
    rsi_in_t b;
    b.origin_x = $urandom; b.origin_y = $urandom; b.origin_z = $urandom;
    b.dir_x = $urandom; b.dir_y = $urandom; b.dir_z = $urandom;
    b.center_x = $urandom; b.center_y = $urandom; b.center_z = $urandom;
    b.radius = RadW'($urandom);
    return b;
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // A ray aimed near a sphere, with the origin sometimes inside it.
  function automatic rsi_in_t random_aimed();
    int cx, cy, cz, rad, ox, oy, oz, sh;
    cx = spread(1 << 26); cy = spread(1 << 26); cz = spread(1 << 26);
    rad = $urandom_range(1 << 10, 1 << 23);
    sh = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) begin
      ox = cx + spread(rad / 2); oy = cy + spread(rad / 2); oz = cz + spread(rad / 2);
      return make_ray(ox, oy, oz, spread(1 << 20), spread(1 << 20), spread(1 << 20),
                      cx, cy, cz, rad);
    end
    ox = spread(1 << 26); oy = spread(1 << 26); oz = spread(1 << 26);
    return make_ray(ox, oy, oz, ((cx - ox) >>> sh) + spread(rad >> sh),
                    ((cy - oy) >>> sh) + spread(rad >> sh),
                    ((cz - oz) >>> sh) + spread(rad >> sh), cx, cy, cz, rad);
  endfunction

  task automatic test_directed();
    int one;
    one = 1 << FracBits;
    // Plain front hit, miss to the side, sphere behind, zero direction.
    send_beat(make_ray(0, 0, 0, one, 0, 0, 10 * one, 0, 0, one));
    send_beat(make_ray(0, 0, 0, one, 0, 0, 10 * one, 5 * one, 0, one));
    send_beat(make_ray(0, 0, 0, -one, 0, 0, 10 * one, 0, 0, one));
    send_beat(make_ray(0, 0, 0, 0, 0, 0, 10 * one, 0, 0, one));
    send_beat(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, one));
    // Origin inside and exactly on the surface.
    send_beat(make_ray(0, 0, 0, 0, one, 0, 0, 0, 0, 3 * one));
    send_beat(make_ray(one, 0, 0, -one, 0, 0, 0, 0, 0, one));
    send_beat(make_ray(one, 0, 0, one, 0, 0, 0, 0, 0, one));
    // Grazing tangent and zero radius.
    send_beat(make_ray(0, one, 0, 0, 0, one, 0, 0, 10 * one, one));
    send_beat(make_ray(0, 0, 0, 0, 0, one, 0, 0, 10 * one, 0));
    // Far root truncating to zero, and a distance beyond the output range.
    send_beat(make_ray(one - 1, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0, one));
    send_beat(make_ray(0, 0, 0, 1, 0, 0, 32'h7FFF0000, 0, 0, one));
    send_beat(make_ray(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    // Field extremes.
    send_beat(make_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
    send_beat(make_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
    send_beat(make_ray(0, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 32'h7FFFFFFF));
    send_beat(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, 32'h7FFFFFFF));
    send_beat(make_ray(0, 0, 0, -1, 0, 0, 32'h80000000, 0, 0, 32'h7FFFFFFF));
  endtask

  task automatic test_aimed_rays(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) send_beat(random_noise());
      else send_beat(random_aimed());
    end
  endtask

  task automatic test_random_noise(int count);
    for (int i = 0; i < count; i++) send_beat(random_noise());
  endtask

  task automatic test_drain_and_resume(int count);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    test_aimed_rays(count);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_aimed_rays(200);
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    test_aimed_rays(250);
    test_drain_and_resume(50);
    sender_idle = 1'b0;
    test_random_noise(100);
    receiver_idle = 1'b0;
    sender_idle = 1'b1;
    test_aimed_rays(80);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    $display("Covered %0d hits (%0d on the far root, %0d saturated) and %0d misses,",
             n_hits, n_far, n_saturated, n_misses);
    $display("with random gaps and stalls on both sides and a full drain mid-run.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d unexpected beats, %0d beats missing",
               mismatches, unexpected, expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d beats outstanding", expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/rsi_pkg.sv
rtl/core/rsi_dot.sv
rtl/core/rsi_disc.sv
rtl/core/rsi_sqrt.sv
rtl/core/rsi_div.sv
rtl/core/ray_sphere_intersection.sv
rtl/core/rsi_checker.sv
test/ray_sphere_intersection_tb.sv
